// File: hdl/mvsm_pkg.sv
// Shared types, field layout and codes for the multi-voice sample mixer.
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

    // Item kinds carried on s_tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_IN_W = 16;
    localparam int POS_W     = 17;
    localparam int GAIN_W    = 10;
    localparam int GAIN_FRAC = 8;
    localparam int LIMIT_W   = 15;

    localparam logic [LIMIT_W-1:0] CLAMP_RESET = 15'd28000;

    // Input word layout, lowest bit first
    localparam int MEM_ADDR_LSB = 0;
    localparam int SAMPLE_LSB   = 16;
    localparam int BASE_LSB     = 32;
    localparam int LEN_LSB      = 48;
    localparam int START_LSB    = 65;
    localparam int LOOP_BIT     = 81;
    localparam int GAIN_LSB     = 82;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 24;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_PREP,
        S_LOAD_RED,
        S_START_SCAN,
        S_TICK_READ,
        S_TICK_EVAL,
        S_TICK_RED,
        S_TICK_MUL,
        S_TICK_ACC,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic vidx_inc;
        logic voice_claim;
        logic set_full;
        logic eval;
        logic voice_stop;
        logic red_load;
        logic red_tick;
        logic red_step;
        logic smem_wr;
        logic mul;
        logic acc;
        logic res_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic              in_valid;
        logic [KIND_W-1:0] in_kind;
        logic              cur_playing;
        logic              cur_stop;
        logic              vidx_last;
        logic              red_done;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/mvsm_ctrl.sv
// Sequencing state machine of the multi-voice sample mixer.
`timescale 1ns / 1ps
`default_nettype none

module mvsm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  mvsm_pkg::sts_t  sts,
    output mvsm_pkg::cmd_t  cmd
);
    import mvsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.in_valid)
                begin
                    case (sts.in_kind)
                        KIND_LOAD:  state_next = S_LOAD_PREP;
                        KIND_START: state_next = S_START_SCAN;
                        KIND_TICK:  state_next = S_TICK_READ;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD_PREP:
            begin
                state_next = S_LOAD_RED;
            end
            S_LOAD_RED:
            begin
                if (sts.red_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_START_SCAN:
            begin
                if (!sts.cur_playing || sts.vidx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_TICK_READ:
            begin
                if (sts.cur_playing)
                begin
                    state_next = S_TICK_EVAL;
                end
                else if (sts.vidx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_TICK_EVAL:
            begin
                if (!sts.cur_stop)
                begin
                    state_next = S_TICK_RED;
                end
                else if (sts.vidx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TICK_READ;
                end
            end
            S_TICK_RED:
            begin
                if (sts.red_done)
                begin
                    state_next = S_TICK_MUL;
                end
            end
            S_TICK_MUL:
            begin
                state_next = S_TICK_ACC;
            end
            S_TICK_ACC:
            begin
                state_next = sts.vidx_last ? S_DONE : S_TICK_READ;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.capture  = sts.in_valid;
            end
            S_LOAD_PREP:
            begin
                cmd.red_load = 1'b1;
            end
            S_LOAD_RED:
            begin
                cmd.red_step = 1'b1;
                cmd.smem_wr  = sts.red_done;
            end
            S_START_SCAN:
            begin
                if (!sts.cur_playing)
                begin
                    cmd.voice_claim = 1'b1;
                end
                else if (sts.vidx_last)
                begin
                    cmd.set_full = 1'b1;
                end
                else
                begin
                    cmd.vidx_inc = 1'b1;
                end
            end
            S_TICK_READ:
            begin
                cmd.vidx_inc = !sts.cur_playing && !sts.vidx_last;
            end
            S_TICK_EVAL:
            begin
                if (sts.cur_stop)
                begin
                    cmd.voice_stop = 1'b1;
                    cmd.vidx_inc   = !sts.vidx_last;
                end
                else
                begin
                    cmd.eval     = 1'b1;
                    cmd.red_load = 1'b1;
                    cmd.red_tick = 1'b1;
                end
            end
            S_TICK_RED:
            begin
                cmd.red_step = 1'b1;
            end
            S_TICK_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_TICK_ACC:
            begin
                cmd.acc      = 1'b1;
                cmd.vidx_inc = !sts.vidx_last;
            end
            S_DONE:
            begin
                cmd.res_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    // An accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && sts.in_valid) |=> (state_reg != S_IDLE))
        else $error("accepted word did not leave idle");

    // Multiply only follows a finished address reduction
    a_mul_after_red: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK_MUL) |-> ($past(state_reg) == S_TICK_RED && $past(sts.red_done)))
        else $error("multiply entered without a reduced address");
`endif

endmodule

`default_nettype wire

// File: hdl/mvsm_datapath.sv
// Datapath of the multi-voice sample mixer: memories, voice state, reducer, mix.
`timescale 1ns / 1ps
`default_nettype none

module mvsm_datapath #(
    parameter int VOICE_COUNT      = 16,
    parameter int SAMPLE_MEM_DEPTH = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mvsm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [mvsm_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mvsm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [mvsm_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  mvsm_pkg::cmd_t                   cmd,
    output mvsm_pkg::sts_t                   sts
);
    import mvsm_pkg::*;

    localparam int VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int ADDR_W     = $clog2(SAMPLE_MEM_DEPTH);
    localparam int RAW_W      = POS_W + 1;
    localparam bit DEPTH_POW2 = ((1 << ADDR_W) == SAMPLE_MEM_DEPTH);
    localparam int RED_STEPS  = (DEPTH_POW2 || (ADDR_W > RAW_W)) ? 0 : (RAW_W - ADDR_W + 1);
    localparam int RCNT_W     = (RED_STEPS < 1) ? 1 : $clog2(RED_STEPS + 1);
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int CONTRIB_W  = PROD_W - GAIN_FRAC;
    localparam int ACC_W      = CONTRIB_W + 1;
    localparam int PAD_W      = M_TDATA_W - SAMPLE_W - 2;

    localparam logic [RAW_W-1:0]  DEPTH_RAW    = RAW_W'(SAMPLE_MEM_DEPTH);
    localparam logic [VIDX_W-1:0] VIDX_LAST    = VIDX_W'(VOICE_COUNT - 1);
    localparam logic [RCNT_W-1:0] RED_LOAD_CNT = RCNT_W'(RED_STEPS);

    // Captured input word
    logic [KIND_W-1:0]    in_kind_reg;
    logic [ADDR_IN_W-1:0] in_addr_reg;
    logic [SAMPLE_W-1:0]  in_sample_reg;
    logic [ADDR_IN_W-1:0] in_base_reg;
    logic [POS_W-1:0]     in_len_reg;
    logic [ADDR_IN_W-1:0] in_start_reg;
    logic                 in_loop_reg;
    logic [GAIN_W-1:0]    in_gain_reg;

    logic [LIMIT_W-1:0]   clamp_reg;
    logic [VIDX_W-1:0]    vidx_reg;
    logic [VIDX_W-1:0]    vidx_next;
    logic [VOICE_COUNT-1:0] playing_reg;
    logic [VOICE_COUNT-1:0] looping_reg;

    // Per-voice parameter memories
    logic [ADDR_IN_W-1:0] base_mem [VOICE_COUNT];
    logic [POS_W-1:0]     len_mem  [VOICE_COUNT];
    logic [POS_W-1:0]     pos_mem  [VOICE_COUNT];
    logic [GAIN_W-1:0]    gain_mem [VOICE_COUNT];
    logic [ADDR_IN_W-1:0] rd_base_reg;
    logic [POS_W-1:0]     rd_len_reg;
    logic [POS_W-1:0]     rd_pos_reg;
    logic [GAIN_W-1:0]    rd_gain_reg;

    logic [POS_W-1:0]     pos_inc;
    logic                 at_end;
    logic                 voice_stop;
    logic [POS_W-1:0]     pos_wrap;

    // Address reducer
    logic [RAW_W-1:0]     red_val_reg;
    logic [RAW_W-1:0]     red_val_next;
    logic [RCNT_W-1:0]    red_cnt_reg;
    logic [RCNT_W-1:0]    red_cnt_next;
    logic [RCNT_W-1:0]    red_sh;
    logic [RAW_W-1:0]     red_sub;
    logic                 red_done;
    logic [ADDR_W-1:0]    red_addr;

    // Sample memory and mix
    logic [SAMPLE_W-1:0]         sample_mem [SAMPLE_MEM_DEPTH];
    logic signed [SAMPLE_W-1:0]  smp_rd_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_adj;
    logic signed [CONTRIB_W-1:0] contrib;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [ACC_W-1:0]     lim_pos;
    logic signed [SAMPLE_W-1:0]  sum_reg;
    logic signed [SAMPLE_W-1:0]  sum_next;

    logic                 started_reg;
    logic                 full_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [SAMPLE_W-1:0]  mixed;

    assign s_tready = cmd.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Status to the controller
    assign sts.in_valid    = s_tvalid;
    assign sts.in_kind     = s_tuser;
    assign sts.cur_playing = playing_reg[vidx_reg];
    assign sts.cur_stop    = voice_stop;
    assign sts.vidx_last   = (vidx_reg == VIDX_LAST);
    assign sts.red_done    = red_done;
    assign sts.out_free    = !m_valid_reg || m_tready;

    // Capture the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_kind_reg <= KIND_LOAD;
        end
        else if (cmd.capture)
        begin
            in_kind_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_addr_reg   <= s_tdata[MEM_ADDR_LSB +: ADDR_IN_W];
            in_sample_reg <= s_tdata[SAMPLE_LSB +: SAMPLE_W];
            in_base_reg   <= s_tdata[BASE_LSB +: ADDR_IN_W];
            in_len_reg    <= s_tdata[LEN_LSB +: POS_W];
            in_start_reg  <= s_tdata[START_LSB +: ADDR_IN_W];
            in_loop_reg   <= s_tdata[LOOP_BIT];
            in_gain_reg   <= s_tdata[GAIN_LSB +: GAIN_W];
        end
    end

    // Clamp limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= CLAMP_RESET;
        end
        else if (cfg_wr_en)
        begin
            clamp_reg <= cfg_wr_data;
        end
    end

    // Voice index
    always_comb
    begin
        vidx_next = vidx_reg;
        if (cmd.capture)
        begin
            vidx_next = '0;
        end
        else if (cmd.vidx_inc)
        begin
            vidx_next = vidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vidx_reg <= '0;
        end
        else
        begin
            vidx_reg <= vidx_next;
        end
    end

    // Playing and looping bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= '0;
            looping_reg <= '0;
        end
        else if (cmd.voice_claim)
        begin
            playing_reg[vidx_reg] <= 1'b1;
            looping_reg[vidx_reg] <= in_loop_reg;
        end
        else if (cmd.voice_stop)
        begin
            playing_reg[vidx_reg] <= 1'b0;
        end
    end

    // Advance the play position; wrap or stop at the end
    always_comb
    begin
        pos_inc    = rd_pos_reg + POS_W'(1);
        at_end     = (pos_inc >= rd_len_reg);
        voice_stop = at_end && !looping_reg[vidx_reg];
        pos_wrap   = at_end ? '0 : pos_inc;
    end

    // Voice parameter memories, registered read at the current voice
    always_ff @(posedge clk)
    begin
        if (cmd.voice_claim)
        begin
            base_mem[vidx_reg] <= in_base_reg;
            len_mem[vidx_reg]  <= in_len_reg;
            gain_mem[vidx_reg] <= in_gain_reg;
        end
        if (cmd.voice_claim)
        begin
            pos_mem[vidx_reg] <= POS_W'(in_start_reg);
        end
        else if (cmd.eval)
        begin
            pos_mem[vidx_reg] <= pos_wrap;
        end
        rd_base_reg <= base_mem[vidx_reg];
        rd_len_reg  <= len_mem[vidx_reg];
        rd_pos_reg  <= pos_mem[vidx_reg];
        rd_gain_reg <= gain_mem[vidx_reg];
    end

    // Reduce an address modulo the memory depth, one shifted subtract a cycle
    assign red_sh   = red_cnt_reg - 1'b1;
    assign red_sub  = DEPTH_RAW << red_sh;
    assign red_done = (red_cnt_reg == '0);
    assign red_addr = ADDR_W'(red_val_reg);

    always_comb
    begin
        red_val_next = red_val_reg;
        red_cnt_next = red_cnt_reg;
        if (cmd.red_load)
        begin
            red_val_next = cmd.red_tick ? (RAW_W'(rd_base_reg) + RAW_W'(rd_pos_reg))
                                        : RAW_W'(in_addr_reg);
            red_cnt_next = RED_LOAD_CNT;
        end
        else if (cmd.red_step && !red_done)
        begin
            if (red_val_reg >= red_sub)
            begin
                red_val_next = red_val_reg - red_sub;
            end
            red_cnt_next = red_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cnt_reg <= '0;
        end
        else
        begin
            red_cnt_reg <= red_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_val_reg <= red_val_next;
    end

    // Sample memory, registered read at the reduced address
    always_ff @(posedge clk)
    begin
        if (cmd.smem_wr)
        begin
            sample_mem[red_addr] <= in_sample_reg;
        end
        smp_rd_reg <= sample_mem[red_addr];
    end

    // Scale by the voice gain
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= smp_rd_reg * $signed({1'b0, rd_gain_reg});
        end
    end

    // Truncate toward zero, accumulate and clamp
    always_comb
    begin
        prod_adj = prod_reg + $signed({{(PROD_W - GAIN_FRAC){1'b0}},
                                       {GAIN_FRAC{prod_reg[PROD_W-1]}}});
        contrib  = prod_adj[PROD_W-1:GAIN_FRAC];
        acc_sum  = ACC_W'(sum_reg) + ACC_W'(contrib);
        lim_pos  = signed'(ACC_W'(clamp_reg));
        sum_next = sum_reg;
        if (cmd.capture)
        begin
            sum_next = '0;
        end
        else if (cmd.acc)
        begin
            if (acc_sum > lim_pos)
            begin
                sum_next = SAMPLE_W'(lim_pos);
            end
            else if (acc_sum < -lim_pos)
            begin
                sum_next = SAMPLE_W'(-lim_pos);
            end
            else
            begin
                sum_next = SAMPLE_W'(acc_sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // Result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            started_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.voice_claim)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // Output register
    assign mixed = (in_kind_reg == KIND_TICK) ? sum_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            m_data_reg <= {{PAD_W{1'b0}}, full_reg, started_reg, mixed};
        end
    end

`ifndef SYNTH
    // Never overwrite a word that is still waiting
    a_res_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending word");

    // Load writes only at a fully reduced address
    a_wr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.smem_wr |-> (red_cnt_reg == '0))
        else $error("sample write before address reduction finished");

    // Running sum stays inside the clamp after every voice
    a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.acc) |-> ((ACC_W'(sum_reg) <= $past(lim_pos)) &&
                            (ACC_W'(sum_reg) >= -$past(lim_pos))))
        else $error("running sum outside clamp limit");

    // A claimed slot was idle
    a_claim_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.voice_claim |-> !playing_reg[vidx_reg])
        else $error("claimed a voice slot that is playing");
`endif

endmodule

`default_nettype wire

// File: hdl/multi_voice_sample_mixer.sv
// Top level of the multi-voice sample mixer: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Multi-voice PCM sample mixer. Each input word is a load (store a signed
// 16-bit sample), a start (claim the lowest idle voice slot) or a tick (mix
// one output sample over all voices in slot order, clamped to +/- the clamp
// limit after every voice); every word returns exactly one result word, and
// a word of any other kind returns an all-zero one. The block works on one
// word at a time, sequenced by the controller walking the voices one slot
// at a time. A load writes the sample at the address the reducer gives; a
// start scans the slots from slot 0 up to the one it claims, or to the last
// slot when all slots play; a tick reads each voice's parameters, stops a
// voice that reaches its end without looping, and for each contributing
// voice advances its position, reduces its address, reads the sample and
// multiplies and accumulates, through the registered voice parameter read,
// the registered sample memory read and the multiply/accumulate steps.
// With a depth that is not a power of two, each load and each contributing
// voice adds the address reduction, one shifted subtract per quotient bit.
// A finished result waits in the output register while the next word is
// taken; a result that is not taken in time holds the block in its last
// step. No clearing pass is run after reset; sample memory reads back
// undefined until written.
module multi_voice_sample_mixer #(
    parameter int VOICE_COUNT      = 16,
    parameter int SAMPLE_MEM_DEPTH = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mem_address[15:0], sample_word[31:16], voice_base[47:32],
    // voice_length[64:48], voice_start[80:65], loop_enable[81], gain[91:82]
    input  logic [mvsm_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [mvsm_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mixed_sample[15:0], voice_started[16], no_free_voice[17]
    output logic [mvsm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [mvsm_pkg::LIMIT_W-1:0]    cfg_wr_data
);
    import mvsm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mvsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mvsm_datapath #(
        .VOICE_COUNT      (VOICE_COUNT),
        .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// File: verif/multi_voice_sample_mixer_test.sv
// Self-checking testbench for the multi-voice sample mixer: random and directed streams.
`timescale 1ns / 1ps

module multi_voice_sample_mixer_test;
    import mvsm_pkg::*;

    localparam int VOICES         = 16;
    localparam int MEM_WORDS      = 65536;
    localparam int HALF_PERIOD    = 6;
    localparam int LIMIT_CYCLES   = 1000000;
    localparam int WORDS_PER_STEP = 155;
    localparam int LIMIT_STEPS    = 6;
    localparam int LOOPER_CAP     = 8;
    localparam int LONG_CAP       = 2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Result word, laid out as on m_tdata
    typedef struct packed {
        logic                full;
        logic                started;
        logic [SAMPLE_W-1:0] mixed;
    } mix_word_t;

    // Tracks voice state and sample memory, queues expected result words
    class mix_scoreboard;
        logic [SAMPLE_W-1:0]  pcm [0:MEM_WORDS-1];
        bit                   loaded [0:MEM_WORDS-1];
        bit                   playing [VOICES];
        bit                   looping [VOICES];
        logic [ADDR_IN_W-1:0] base [VOICES];
        logic [POS_W-1:0]     len [VOICES];
        logic [POS_W-1:0]     pos [VOICES];
        logic [GAIN_W-1:0]    gain [VOICES];
        logic [LIMIT_W-1:0]   limit;
        mix_word_t            pending_mix [$];
        int                   errors;

        function new();
            limit  = CLAMP_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return pending_mix.size();
        endfunction

        function int free_slot();
            for (int v = 0; v < VOICES; v++)
                if (!playing[v])
                    return v;
            return -1;
        endfunction

        // Return 1 if voice v reads a sample on the next tick; give its
        // next position and the address it reads
        function bit voice_step(int v, output logic [POS_W-1:0] nxt,
                                output logic [ADDR_IN_W-1:0] a);
            nxt = pos[v] + 1'b1;
            a   = base[v] + pos[v][ADDR_IN_W-1:0];
            if (nxt >= len[v])
            begin
                if (!looping[v])
                    return 0;
                nxt = '0;
            end
            return 1;
        endfunction

        // List the words the next tick would read that were never loaded
        function void missing_words(output int addrs[$]);
            logic [POS_W-1:0]     nxt;
            logic [ADDR_IN_W-1:0] a;
            addrs = {};
            for (int v = 0; v < VOICES; v++)
                if (playing[v] && voice_step(v, nxt, a) && !loaded[a])
                    addrs.push_back(int'(a));
        endfunction

        // Walk the voices in slot order, clamping the sum after each one
        function mix_word_t mix_tick();
            mix_word_t            r;
            int                   acc;
            int                   lim;
            int                   s;
            int                   c;
            logic [POS_W-1:0]     nxt;
            logic [ADDR_IN_W-1:0] a;
            r   = '0;
            acc = 0;
            lim = int'(limit);
            for (int v = 0; v < VOICES; v++)
            begin
                if (!playing[v])
                    continue;
                if (!voice_step(v, nxt, a))
                begin
                    playing[v] = 0;
                    continue;
                end
                pos[v] = nxt;
                s = int'($signed(pcm[a]));
                c = (s * int'(gain[v])) / 256;
                acc = acc + c;
                if (acc > lim)
                    acc = lim;
                if (acc < -lim)
                    acc = -lim;
            end
            r.mixed = acc[SAMPLE_W-1:0];
            return r;
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [S_TDATA_W-1:0] w);
            mix_word_t r;
            int        slot;
            r = '0;
            case (kind)
                KIND_LOAD:
                begin
                    pcm[w[MEM_ADDR_LSB +: ADDR_IN_W]]    = w[SAMPLE_LSB +: SAMPLE_W];
                    loaded[w[MEM_ADDR_LSB +: ADDR_IN_W]] = 1;
                end
                KIND_START:
                begin
                    slot = free_slot();
                    if (slot >= 0)
                    begin
                        playing[slot] = 1;
                        base[slot]    = w[BASE_LSB +: ADDR_IN_W];
                        len[slot]     = w[LEN_LSB +: POS_W];
                        pos[slot]     = {1'b0, w[START_LSB +: ADDR_IN_W]};
                        looping[slot] = w[LOOP_BIT];
                        gain[slot]    = w[GAIN_LSB +: GAIN_W];
                        r.started     = 1;
                    end
                    else
                        r.full = 1;
                end
                KIND_TICK:
                    r = mix_tick();
                default:
                    ;
            endcase
            pending_mix.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] w);
            mix_word_t got;
            mix_word_t want;
            got = w[$bits(mix_word_t)-1:0];
            if (pending_mix.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: mixed %0d started %0b full %0b",
                             $signed(got.mixed), got.started, got.full);
                return;
            end
            want = pending_mix.pop_front();
            if (got.mixed !== want.mixed || got.started !== want.started ||
                got.full !== want.full)
            begin
                errors++;
                if (errors <= 10)
                    $display("bad result word: mixed %0d/%0d started %0b/%0b full %0b/%0b",
                             $signed(want.mixed), $signed(got.mixed), want.started,
                             got.started, want.full, got.full);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en;
    logic [LIMIT_W-1:0]     cfg_wr_data;

    mix_scoreboard sb = new();
    bit            calm;
    int            sent;
    int            cycles;

    multi_voice_sample_mixer #(
        .VOICE_COUNT      (VOICES),
        .SAMPLE_MEM_DEPTH (MEM_WORDS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #HALF_PERIOD clk = ~clk;
    end

    // Note accepted words on both sides
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_word();
        logic [S_TDATA_W-1:0] w;
        w = {$urandom, $urandom, $urandom};
        w[S_TDATA_W-1:GAIN_LSB+GAIN_W] = '0;
        return w;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pcm_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold the word until the block takes it; returns at a falling edge
    task automatic push_word(input logic [KIND_W-1:0] kind, input logic [S_TDATA_W-1:0] w);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic load_word(input logic [ADDR_IN_W-1:0] addr, input logic [SAMPLE_W-1:0] val);
        logic [S_TDATA_W-1:0] w;
        w = noise_word();
        w[MEM_ADDR_LSB +: ADDR_IN_W] = addr;
        w[SAMPLE_LSB +: SAMPLE_W]    = val;
        push_word(KIND_LOAD, w);
    endtask

    task automatic start_voice(input logic [ADDR_IN_W-1:0] b, input logic [POS_W-1:0] ln,
                               input logic [ADDR_IN_W-1:0] st, input logic lp,
                               input logic [GAIN_W-1:0] g);
        logic [S_TDATA_W-1:0] w;
        w = noise_word();
        w[BASE_LSB +: ADDR_IN_W]  = b;
        w[LEN_LSB +: POS_W]       = ln;
        w[START_LSB +: ADDR_IN_W] = st;
        w[LOOP_BIT]               = lp;
        w[GAIN_LSB +: GAIN_W]     = g;
        push_word(KIND_START, w);
    endtask

    // Load every word the tick is about to read that was never written
    task automatic tick();
        int need[$];
        sb.missing_words(need);
        foreach (need[i])
            load_word(ADDR_IN_W'(need[i]), pcm_value());
        push_word(KIND_TICK, noise_word());
    endtask

    task automatic random_start();
        int ln;
        int st;
        int g;
        int loopers;
        int longs;
        bit lp;
        loopers = 0;
        longs   = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (sb.playing[v] && sb.looping[v])
                loopers++;
            if (sb.playing[v] && !sb.looping[v] && sb.len[v] > 400)
                longs++;
        end
        case ($urandom_range(0, 19))
            0:       ln = 0;
            1:       ln = (longs < LONG_CAP) ? $urandom_range(65536, 131071)
                                             : $urandom_range(1, 24);
            2, 3, 4: ln = $urandom_range(25, 400);
            default: ln = $urandom_range(1, 24);
        endcase
        if ($urandom_range(0, 6) == 0)
            st = $urandom_range(0, 65535);
        else if (ln > 1)
            st = $urandom_range(0, (ln - 1 > 65535) ? 65535 : ln - 1);
        else
            st = 0;
        lp = (loopers < LOOPER_CAP) && ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0, 1:    g = 256;
            2:       g = $urandom_range(513, 1023);
            default: g = $urandom_range(0, 512);
        endcase
        start_voice(ADDR_IN_W'($urandom), POS_W'(ln), ADDR_IN_W'(st), lp, GAIN_W'(g));
    endtask

    // When the chosen voice plays, aim half such loads at its track so the mix picks them up
    task automatic random_load();
        int v;
        v = $urandom_range(0, VOICES - 1);
        if (sb.playing[v] && $urandom_range(0, 1) == 0)
            load_word(ADDR_IN_W'(sb.base[v] + $urandom_range(0, 31)), pcm_value());
        else
            load_word(ADDR_IN_W'($urandom), pcm_value());
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 48)
            tick();
        else if (r < 73)
            random_start();
        else if (r < 95)
            random_load();
        else
            push_word(KIND_SPARE, noise_word());
    endtask

    // Stop sending and wait until every result word is back
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_wr_data = v;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.set_limit(v);
    endtask

    // Corner cases: extremes, address wrap, zero length, start past end,
    // truncation of a negative product, gain above unity, all slots busy
    task automatic directed();
        push_word(KIND_SPARE, noise_word());
        load_word(16'hFFFF, 16'h7FFF);
        load_word(16'h0000, 16'h8000);
        load_word(16'h0001, 16'hFFFF);
        start_voice(16'hFFFF, 17'd3, 16'd0, 1'b0, 10'd1023);
        start_voice(16'h0001, 17'd1, 16'd0, 1'b1, 10'd128);
        start_voice(16'h0000, 17'd0, 16'd0, 1'b1, 10'd0);
        start_voice(16'h0005, 17'd4, 16'd9, 1'b0, 10'd512);
        start_voice(16'd100, 17'd2, 16'd40000, 1'b1, 10'd512);
        repeat (3) tick();
        while (sb.free_slot() >= 0)
            start_voice(ADDR_IN_W'($urandom), 17'd6, 16'd0, 1'b0, 10'd256);
        start_voice(ADDR_IN_W'($urandom), 17'd6, 16'd0, 1'b0, 10'd256);
        repeat (2) tick();
    endtask

    // Receiver: stall a random number of cycles before each result word
    initial
    begin
        int n;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            n = idle_cycles();
            if (n > 0)
            begin
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        int                 goal;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_LOAD;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        calm        = 1'b0;
        sent        = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed();
        settle();

        // Each step runs with its own clamp limit; one step runs with no idling
        for (int step = 0; step < LIMIT_STEPS; step++)
        begin
            case (step)
                0:       lim = '0;
                1:       lim = 15'h7FFF;
                2:       lim = 15'd1;
                3:       lim = LIMIT_W'($urandom_range(1, 32766));
                4:       lim = CLAMP_RESET;
                default: lim = LIMIT_W'($urandom_range(0, 32767));
            endcase
            write_limit(lim);
            calm = (step == 3);
            goal = sent + WORDS_PER_STEP;
            while (sent < goal)
                random_item();
            settle();
        end

        calm = 1'b0;
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hdl/mvsm_pkg.sv
hdl/mvsm_ctrl.sv
hdl/mvsm_datapath.sv
hdl/multi_voice_sample_mixer.sv
verif/multi_voice_sample_mixer_test.sv
